// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

   localparam int NumClasses        = 3;
   localparam int QueueDepthDefault = 16;
   localparam int TagWidthDefault   = 16;
   localparam int ItemTagWidth      = 16;
   localparam int ServiceWidth      = 16;
   localparam int ClassWidth        = 2;
   localparam int StatusWidth       = 3;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [ClassWidth-1:0] {
      CLASS_EMERGENCY = 2'd0,
      CLASS_PASSENGER = 2'd1,
      CLASS_CARGO     = 2'd2,
      CLASS_UNKNOWN   = 2'd3
   } class_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_ENQUEUED = 3'd0,
      ST_SERVED   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_UNKNOWN  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      status_type              status;
      class_type               served_class;
      logic [ServiceWidth-1:0] service_number;
   } result_type;

endpackage

// ===== rtl/core/spq_req_if.sv =====
interface spq_req_if import spq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    operation;
   logic [ClassWidth-1:0]   traffic_class;
   logic [ItemTagWidth-1:0] item_tag;

   modport source (output valid, operation, traffic_class, item_tag, input ready);
   modport sink   (input valid, operation, traffic_class, item_tag, output ready);
endinterface

// ===== rtl/core/spq_rsp_if.sv =====
interface spq_rsp_if import spq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [StatusWidth-1:0]  status;
   logic [ClassWidth-1:0]   served_class;
   logic [ItemTagWidth-1:0] served_tag;
   logic [ServiceWidth-1:0] service_number;

   modport source (output valid, status, served_class, served_tag, service_number,
                   input ready);
   modport sink   (input valid, status, served_class, served_tag, service_number,
                   output ready);
endinterface

// ===== rtl/core/spq_tag_store.sv =====
module spq_tag_store import spq_pkg::*; #(
   parameter int ENTRIES = 48,
   parameter int ADDR_W  = 6,
   parameter int DATA_W  = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [ENTRIES];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
module spq_ctrl import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int PTR_W       = 4,
   parameter int ADDR_W      = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  operation,
   input  logic [ClassWidth-1:0] traffic_class,
   output logic                  wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic                  rd_en,
   output logic [ADDR_W-1:0]     rd_addr,
   output result_type            result
);

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [PTR_W-1:0]        head_ff  [NumClasses];
   logic [PTR_W-1:0]        head_in  [NumClasses];
   logic [PTR_W-1:0]        tail_ff  [NumClasses];
   logic [PTR_W-1:0]        tail_in  [NumClasses];
   logic [COUNT_W-1:0]      count_ff [NumClasses];
   logic [COUNT_W-1:0]      count_in [NumClasses];
   logic [ServiceWidth-1:0] svc_ff;
   logic [ServiceWidth-1:0] svc_in;
   class_type               cls;
   class_type               pick;
   logic                    any_waiting;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign cls = class_type'(traffic_class);

   always_comb begin
      pick        = CLASS_EMERGENCY;
      any_waiting = 1'b0;
      for (int c = NumClasses - 1; c >= 0; c--) begin
         if (count_ff[c] != '0) begin
            pick        = class_type'(c);
            any_waiting = 1'b1;
         end
      end
   end

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      svc_in         = svc_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      rd_en          = 1'b0;
      rd_addr        = {pick, head_ff[pick]};
      result         = '0;
      result.status  = ST_EMPTY;
      if (op_type'(operation) == OP_ENQUEUE) begin
         if (cls == CLASS_UNKNOWN) begin
            result.status = ST_UNKNOWN;
         end else if (count_ff[cls] == COUNT_W'(QUEUE_DEPTH)) begin
            result.status = ST_FULL;
         end else begin
            result.status = ST_ENQUEUED;
            wr_en         = accept;
            wr_addr       = {cls, tail_ff[cls]};
            if (accept) begin
               tail_in[cls]  = advance(tail_ff[cls]);
               count_in[cls] = count_ff[cls] + COUNT_W'(1);
            end
         end
      end else if (any_waiting) begin
         result.status         = ST_SERVED;
         result.served_class   = pick;
         result.service_number = svc_ff;
         rd_en                 = accept;
         if (accept) begin
            head_in[pick]  = advance(head_ff[pick]);
            count_in[pick] = count_ff[pick] - COUNT_W'(1);
            svc_in         = svc_ff + ServiceWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NumClasses; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
         svc_ff <= ServiceWidth'(1);
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         svc_ff   <= svc_in;
      end
   end

   for (genvar g = 0; g < NumClasses; g++) begin : g_count_chk
      assert property (@(posedge clock) disable iff (reset)
         count_ff[g] <= COUNT_W'(QUEUE_DEPTH))
      else $error("Occupancy count exceeds the queue depth.");
   end

   assert property (@(posedge clock) disable iff (reset)
      accept && result.status == ST_EMPTY |->
         count_ff[0] == '0 && count_ff[1] == '0 && count_ff[2] == '0)
   else $error("Nothing-waiting status reported while a class holds tags.");

   assert property (@(posedge clock) disable iff (reset)
      accept && result.status == ST_SERVED |=> svc_ff == $past(svc_ff) + ServiceWidth'(1))
   else $error("Service number did not advance after a service.");

   assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
   else $error("Tag store written and read for the same request.");

endmodule

// ===== rtl/core/strict_priority_three_class_queue.sv =====
// Strict-priority scheduler over three classes (emergency, passenger, cargo), each with a
// ring-buffer FIFO of QUEUE_DEPTH tags. Every request transfer gives exactly one response
// transfer, in the cycle after it, held in the output register until it is taken. A new request is
// accepted in every cycle in which the response register is empty or is being emptied, so the
// sustained rate is one request per cycle while responses are taken; the served tag comes from the
// registered read port of the tag memory. On a response with any status other than served, the
// class, tag and service number fields are zero. There is no clearing pass after reset.
module strict_priority_three_class_queue import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int TAG_WIDTH   = TagWidthDefault
) (
   input logic     clock,
   input logic     reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W  = PTR_W + ClassWidth;
   localparam int ENTRIES = NumClasses * (2 ** PTR_W);
   localparam int STORE_W = (TAG_WIDTH < ItemTagWidth) ? TAG_WIDTH : ItemTagWidth;

   logic               accept;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [STORE_W-1:0] rd_data;
   result_type         result;
   result_type         result_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   spq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PTR_W       (PTR_W),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .operation     (req_chan.operation),
      .traffic_class (req_chan.traffic_class),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .result        (result)
   );

   spq_tag_store #(
      .ENTRIES (ENTRIES),
      .ADDR_W  (ADDR_W),
      .DATA_W  (STORE_W)
   ) u_tag_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.item_tag[STORE_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = result_ff.status;
   assign rsp_chan.served_class   = result_ff.served_class;
   assign rsp_chan.service_number = result_ff.service_number;
   assign rsp_chan.served_tag     = (result_ff.status == ST_SERVED) ?
                                    ItemTagWidth'(rd_data) : '0;

endmodule
